// ----- rtl/tts_pkg.sv -----
// shared types and constants for the tensor tile source index generator
// no dependencies; imported by every module of the block

package tts_pkg;

   localparam int DATA_BITS      = 32;  // width of indices, strides and lengths
   localparam int REG_DIMS       = 4;   // dimensions held by the stride/length registers
   localparam int RANK_BITS      = 3;
   localparam int MAX_RANK_DEF   = 4;
   localparam int INDEX_BITS_DEF = 32;

   localparam int CSR_ADDR_BITS  = 6;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_INDEX_LSB  = 3;   // registers sit on 8-byte boundaries
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RANK    = 3'd0,
      CSR_COUNT   = 3'd1,
      CSR_OSTR_LO = 3'd2,
      CSR_OSTR_HI = 3'd3,
      CSR_ISTR_LO = 3'd4,
      CSR_ISTR_HI = 3'd5,
      CSR_ILEN_LO = 3'd6,
      CSR_ILEN_HI = 3'd7
   } csr_reg_type;

   // one request travelling down the cell chain
   typedef struct packed {
      logic                 valid;
      logic [DATA_BITS-1:0] dest;  // output index, passed along untouched
      logic [DATA_BITS-1:0] num;   // dividend, shifting out as quotient bits shift in
      logic [DATA_BITS-1:0] rem;   // partial remainder
      logic [DATA_BITS-1:0] keep;  // offset carried past the wrap division
      logic [DATA_BITS-1:0] acc;   // source index sum so far
   } item_type;

   // per-dimension settings; an unused dimension has zero out stride and in length
   typedef struct packed {
      logic [DATA_BITS-1:0] out_stride;
      logic [DATA_BITS-1:0] in_stride;
      logic [DATA_BITS-1:0] in_len;
   } dim_cfg_type;

endpackage

// ----- rtl/tts_div_cell.sv -----
// one restoring division step: shifts one dividend bit into the remainder
// depends on tts_pkg

module tts_div_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [tts_pkg::DATA_BITS-1:0] divisor,
   input  tts_pkg::item_type             item_i,
   output tts_pkg::item_type             item_o
);
   import tts_pkg::*;

   logic [DATA_BITS:0] trial;
   logic [DATA_BITS:0] diff;
   logic               fits;
   item_type           item_in;
   item_type           item_ff;

   always_comb begin
      trial   = {item_i.rem, item_i.num[DATA_BITS-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      item_in = item_i;
      // zero divisor: every step fits and the remainder ends up as the dividend
      item_in.rem = fits ? diff[DATA_BITS-1:0] : trial[DATA_BITS-1:0];
      item_in.num = {item_i.num[DATA_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff <= item_in;
      end
   end

   assign item_o = item_ff;

endmodule

// ----- rtl/tts_mac_cell.sv -----
// wraps the coordinate and adds coordinate times input stride to the sum
// depends on tts_pkg

module tts_mac_cell #(
   parameter int INDEX_BITS = tts_pkg::INDEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic [tts_pkg::DATA_BITS-1:0] in_stride,
   input  logic [tts_pkg::DATA_BITS-1:0] in_len,
   input  tts_pkg::item_type             item_i,
   output tts_pkg::item_type             item_o
);
   import tts_pkg::*;

   // only the low bits of the sum reach the port
   localparam int ACC_BITS = (INDEX_BITS < DATA_BITS) ? INDEX_BITS : DATA_BITS;

   logic [DATA_BITS-1:0] wrapped;
   logic [DATA_BITS-1:0] prod;
   logic [ACC_BITS-1:0]  sum_low;
   item_type             item_in;
   item_type             item_ff;

   always_comb begin
      wrapped = (in_len == '0) ? '0 : item_i.rem;
      prod    = in_stride * wrapped;
      sum_low = ACC_BITS'(item_i.acc) + ACC_BITS'(prod);
      item_in = item_i;
      item_in.acc = DATA_BITS'(sum_low);
      // next dimension divides the remaining offset
      item_in.num = item_i.keep;
      item_in.rem = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff <= item_in;
      end
   end

   assign item_o = item_ff;

endmodule

// ----- rtl/tts_dim.sv -----
// one dimension: a row of division cells for offset / out stride, then for
// coordinate % in length, closed by a multiply-accumulate cell
// depends on tts_pkg, tts_div_cell, tts_mac_cell

module tts_dim #(
   parameter int INDEX_BITS = tts_pkg::INDEX_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  tts_pkg::dim_cfg_type dim_cfg,
   input  tts_pkg::item_type    item_i,
   output tts_pkg::item_type    item_o
);
   import tts_pkg::*;

   localparam int CELLS = 2 * DATA_BITS;

   item_type link [0:CELLS];

   assign link[0] = item_i;

   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      item_type             cell_in;
      logic [DATA_BITS-1:0] divisor;

      if (j == DATA_BITS) begin : g_turn
         // quotient becomes the coordinate, remainder the new offset
         always_comb begin
            cell_in      = link[j];
            cell_in.keep = link[j].rem;
            cell_in.num  = (dim_cfg.out_stride == '0) ? '0 : link[j].num;
            cell_in.rem  = '0;
         end
      end else begin : g_pass
         assign cell_in = link[j];
      end

      assign divisor = (j < DATA_BITS) ? dim_cfg.out_stride : dim_cfg.in_len;

      tts_div_cell u_div (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .divisor (divisor),
         .item_i  (cell_in),
         .item_o  (link[j+1])
      );
   end

   tts_mac_cell #(
      .INDEX_BITS (INDEX_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_stride (dim_cfg.in_stride),
      .in_len    (dim_cfg.in_len),
      .item_i    (link[CELLS]),
      .item_o    (item_o)
   );

endmodule

// ----- rtl/tensor_tile_source_index.sv -----
// Tensor tile source index generator. Takes one output element index per
// cycle and returns the matching source index of the tiled input, together
// with the output index; indices at or above element_count are taken and
// dropped. Each dimension is a row of 32 bit-per-cell restoring division
// cells for offset / out stride, 32 more for coordinate % in length, and
// one multiply-accumulate cell; the rows are chained, and a two-entry
// output buffer holds finished results, so requests keep flowing at one
// per cycle while the output side accepts. Dimensions beyond rank_in_use
// act as a zero stride and zero length. Configuration must be written
// only while no request is in flight; the block does not enforce this.
//
// depends on tts_pkg, tts_dim (and through it tts_div_cell, tts_mac_cell)

module tensor_tile_source_index #(
   parameter int MAX_RANK   = tts_pkg::MAX_RANK_DEF,
   parameter int INDEX_BITS = tts_pkg::INDEX_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel, tdata: out_index[31:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tts_pkg::DATA_BITS-1:0]     req_tdata,
   // result channel, tdata: dest_index[31:0], src_index[63:32]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*tts_pkg::DATA_BITS-1:0]   rsp_tdata,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tts_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tts_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tts_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);
   import tts_pkg::*;

   localparam int DIMS = (MAX_RANK < REG_DIMS) ? MAX_RANK : REG_DIMS;

   // configuration registers
   logic [RANK_BITS-1:0]     rank_ff;
   logic [DATA_BITS-1:0]     count_ff;
   logic [CSR_DATA_BITS-1:0] ostr_lo_ff, ostr_hi_ff;
   logic [CSR_DATA_BITS-1:0] istr_lo_ff, istr_hi_ff;
   logic [CSR_DATA_BITS-1:0] ilen_lo_ff, ilen_hi_ff;
   csr_reg_type              csr_sel;
   logic                     csr_wr;

   assign csr_pready = 1'b1;
   assign csr_sel    = csr_reg_type'(csr_paddr[CSR_INDEX_LSB +: CSR_INDEX_BITS]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff    <= RANK_BITS'(1);
         count_ff   <= '0;
         ostr_lo_ff <= '0;
         ostr_hi_ff <= '0;
         istr_lo_ff <= '0;
         istr_hi_ff <= '0;
         ilen_lo_ff <= '0;
         ilen_hi_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_sel)
            CSR_RANK:    rank_ff    <= csr_pwdata[RANK_BITS-1:0];
            CSR_COUNT:   count_ff   <= csr_pwdata[DATA_BITS-1:0];
            CSR_OSTR_LO: ostr_lo_ff <= csr_pwdata;
            CSR_OSTR_HI: ostr_hi_ff <= csr_pwdata;
            CSR_ISTR_LO: istr_lo_ff <= csr_pwdata;
            CSR_ISTR_HI: istr_hi_ff <= csr_pwdata;
            CSR_ILEN_LO: ilen_lo_ff <= csr_pwdata;
            CSR_ILEN_HI: ilen_hi_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         CSR_RANK:    csr_prdata = CSR_DATA_BITS'(rank_ff);
         CSR_COUNT:   csr_prdata = CSR_DATA_BITS'(count_ff);
         CSR_OSTR_LO: csr_prdata = ostr_lo_ff;
         CSR_OSTR_HI: csr_prdata = ostr_hi_ff;
         CSR_ISTR_LO: csr_prdata = istr_lo_ff;
         CSR_ISTR_HI: csr_prdata = istr_hi_ff;
         CSR_ILEN_LO: csr_prdata = ilen_lo_ff;
         CSR_ILEN_HI: csr_prdata = ilen_hi_ff;
         default:     csr_prdata = '0;
      endcase
   end

   // chain control: the whole row moves unless the output buffer is full
   logic [1:0] cnt_ff;
   logic       advance;
   logic       push;
   logic       pop;

   assign advance    = (cnt_ff != 2'd2);
   assign req_tready = advance;

   // entry register: out-of-range requests enter as bubbles
   item_type entry_in;
   item_type entry_ff;

   always_comb begin
      entry_in       = '0;
      entry_in.valid = req_tvalid && (req_tdata < count_ff);
      entry_in.dest  = req_tdata;
      entry_in.num   = req_tdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         entry_ff <= entry_in;
      end
   end

   // dimension rows
   item_type link [0:DIMS];

   assign link[0] = entry_ff;

   for (genvar d = 0; d < DIMS; d++) begin : g_dim
      localparam int LSB = (d % 2) * DATA_BITS;

      dim_cfg_type dim_cfg;
      logic        active;

      assign active = (rank_ff > RANK_BITS'(d));

      always_comb begin
         if (d < 2) begin
            dim_cfg.out_stride = ostr_lo_ff[LSB +: DATA_BITS];
            dim_cfg.in_stride  = istr_lo_ff[LSB +: DATA_BITS];
            dim_cfg.in_len     = ilen_lo_ff[LSB +: DATA_BITS];
         end else begin
            dim_cfg.out_stride = ostr_hi_ff[LSB +: DATA_BITS];
            dim_cfg.in_stride  = istr_hi_ff[LSB +: DATA_BITS];
            dim_cfg.in_len     = ilen_hi_ff[LSB +: DATA_BITS];
         end
         if (!active) begin
            dim_cfg.out_stride = '0;
            dim_cfg.in_len     = '0;
         end
      end

      tts_dim #(
         .INDEX_BITS (INDEX_BITS)
      ) u_dim (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .dim_cfg (dim_cfg),
         .item_i  (link[d]),
         .item_o  (link[d+1])
      );
   end

   // two-entry output buffer
   logic [2*DATA_BITS-1:0] head_ff;
   logic [2*DATA_BITS-1:0] second_ff;
   logic [2*DATA_BITS-1:0] result;

   assign result     = {link[DIMS].acc, link[DIMS].dest};
   assign push       = advance && link[DIMS].valid;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + 2'd1;
            2'b01:   cnt_ff <= cnt_ff - 2'd1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         head_ff <= (cnt_ff == 2'd2) ? second_ff : result;
      end else if (push && cnt_ff == 2'd0) begin
         head_ff <= result;
      end
      if (push && !pop && cnt_ff == 2'd1) begin
         second_ff <= result;
      end
   end

   // out-of-range request never reaches the chain
   a_drop_range: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata >= count_ff)) |=> !entry_ff.valid)
      else $error("out-of-range request entered the chain");

   // in-range request enters the chain with its index
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tdata < count_ff))
      |=> (entry_ff.valid && (entry_ff.dest == $past(req_tdata))))
      else $error("accepted request missing from entry stage");

   // a full output buffer holds off new requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (!req_tready && !push))
      else $error("request moved while output buffer full");

   // reset empties the buffer and the entry stage
   a_reset_clear: assert property (@(posedge clock)
      reset |=> ((cnt_ff == 2'd0) && !entry_ff.valid))
      else $error("reset left a request in flight");

endmodule

// ----- test/tb_tensor_tile_source_index.sv -----
`timescale 1ns / 100ps
// testbench for tensor_tile_source_index: streams output indices under tile shapes and raw
// register settings and checks each source index against a predictor in this file
// depends on tts_pkg and the tensor_tile_source_index rtl

module tb_tensor_tile_source_index;
   import tts_pkg::*;

   localparam int LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_CYCLES = 2 + 65 * REG_DIMS + 40;
   localparam int TARGET_ITEMS = 1150;

   // same layout as rsp_tdata: dest_index low, src_index high
   typedef struct packed {
      logic [DATA_BITS-1:0] src;
      logic [DATA_BITS-1:0] dest;
   } tile_result_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [DATA_BITS-1:0]       req_tdata;   // out_index[31:0]
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [2*DATA_BITS-1:0]     rsp_tdata;   // dest_index[31:0], src_index[63:32]
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   logic [CSR_DATA_BITS-1:0]   csr_model [8];
   logic [DATA_BITS-1:0]       out_index_queue [$];
   tile_result_type            results_due [$];
   int                         pushed_count;
   int                         accepted_count = 0;
   int                         error_count;
   int                         cycle_count = 0;
   int                         send_gap;
   int                         stall_left;
   bit                         tx_steady;
   bit                         rx_steady;

   // shape to be loaded by load_shape
   logic [2:0]                 rank_set;
   logic [DATA_BITS-1:0]       count_set;
   logic [DATA_BITS-1:0]       ostr_set [4];
   logic [DATA_BITS-1:0]       istr_set [4];
   logic [DATA_BITS-1:0]       ilen_set [4];

   tensor_tile_source_index DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [DATA_BITS-1:0] pick_dim(csr_reg_type lo, csr_reg_type hi, int d);
      logic [CSR_DATA_BITS-1:0] word;
      word = (d < 2) ? csr_model[lo] : csr_model[hi];
      return (d % 2 == 1) ? word[63:32] : word[31:0];
   endfunction

   function automatic logic [DATA_BITS-1:0] tile_source(logic [DATA_BITS-1:0] out_index);
      dim_cfg_type          dim;
      logic [DATA_BITS-1:0] offset;
      logic [DATA_BITS-1:0] coord;
      logic [DATA_BITS-1:0] src;
      int                   dims;
      offset = out_index;
      src    = '0;
      dims   = int'(csr_model[CSR_RANK][RANK_BITS-1:0]);
      if (dims > MAX_RANK_DEF) dims = MAX_RANK_DEF;
      if (dims > REG_DIMS) dims = REG_DIMS;
      for (int d = 0; d < dims; d++) begin
         dim.out_stride = pick_dim(CSR_OSTR_LO, CSR_OSTR_HI, d);
         dim.in_stride  = pick_dim(CSR_ISTR_LO, CSR_ISTR_HI, d);
         dim.in_len     = pick_dim(CSR_ILEN_LO, CSR_ILEN_HI, d);
         coord = '0;
         if (dim.out_stride != 0) begin
            coord  = offset / dim.out_stride;
            offset = offset % dim.out_stride;
         end
         coord = (dim.in_len != 0) ? coord % dim.in_len : '0;
         src   = src + dim.in_stride * coord;
      end
      return src;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DATA_BITS-1:0] raw_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4: return $urandom_range(1, 64);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DATA_BITS-1:0] next_index();
      int r;
      r = $urandom_range(0, 99);
      if (count_set != 0 && r < 85) return $urandom_range(0, count_set - 1);
      if (r < 93) return count_set + $urandom_range(0, 3);
      return $urandom;
   endfunction

   task automatic report(string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // write one register, then read it back
   task automatic csr_set(csr_reg_type r, logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] back;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(r) << CSR_INDEX_LSB;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_model[r] = value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      back = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (back !== value)
         report($sformatf("register %s reads %h, written %h", r.name(), back, value));
   endtask

   task automatic load_shape();
      csr_set(CSR_RANK, CSR_DATA_BITS'(rank_set));
      csr_set(CSR_COUNT, CSR_DATA_BITS'(count_set));
      csr_set(CSR_OSTR_LO, {ostr_set[1], ostr_set[0]});
      csr_set(CSR_OSTR_HI, {ostr_set[3], ostr_set[2]});
      csr_set(CSR_ISTR_LO, {istr_set[1], istr_set[0]});
      csr_set(CSR_ISTR_HI, {istr_set[3], istr_set[2]});
      csr_set(CSR_ILEN_LO, {ilen_set[1], ilen_set[0]});
      csr_set(CSR_ILEN_HI, {ilen_set[3], ilen_set[2]});
   endtask

   // tiled shape with standard strides; dims past the rank get junk
   task automatic random_tile_shape();
      int od [4];
      rank_set = 3'($urandom_range(1, REG_DIMS));
      for (int d = REG_DIMS - 1; d >= 0; d--) begin
         ilen_set[d] = $urandom_range(1, 5);
         od[d] = ilen_set[d] * $urandom_range(1, 3);
         if ($urandom_range(0, 7) == 0) od[d] = ilen_set[d] * $urandom_range(4, 40);
         if (d >= rank_set) begin
            ostr_set[d] = raw_word();
            istr_set[d] = raw_word();
            ilen_set[d] = raw_word();
         end else if (d == rank_set - 1) begin
            ostr_set[d] = 1;
            istr_set[d] = 1;
         end else begin
            ostr_set[d] = ostr_set[d+1] * od[d+1];
            istr_set[d] = istr_set[d+1] * ilen_set[d+1];
         end
      end
      count_set = ostr_set[0] * od[0];
   endtask

   task automatic random_raw_shape();
      int r;
      rank_set = 3'($urandom_range(0, 7));
      for (int d = 0; d < REG_DIMS; d++) begin
         ostr_set[d] = raw_word();
         istr_set[d] = raw_word();
         ilen_set[d] = raw_word();
      end
      r = $urandom_range(0, 9);
      if (r < 5) count_set = '1;
      else if (r < 8) count_set = $urandom;
      else count_set = $urandom_range(0, 300);
   endtask

   task automatic queue_index(logic [DATA_BITS-1:0] out_index);
      out_index_queue.push_back(out_index);
      pushed_count++;
   endtask

   // dropped requests leave no trace, so wait out the pipeline before touching registers
   task automatic finish_phase();
      while (accepted_count != pushed_count) @(posedge clock);
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tdata < csr_model[CSR_COUNT][DATA_BITS-1:0])
               results_due.push_back({tile_source(req_tdata), req_tdata});
            accepted_count++;
            send_gap = tx_steady ? 0 : idle_len();
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (out_index_queue.size() > 0) begin
               req_tdata  <= out_index_queue.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : result_check
      tile_result_type got;
      tile_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (results_due.size() == 0) begin
               report($sformatf("unexpected result dest %h src %h", got.dest, got.src));
            end else begin
               want = results_due.pop_front();
               if (got.dest !== want.dest)
                  report($sformatf("dest_index %h, expected %h", got.dest, want.dest));
               if (got.src !== want.src)
                  report($sformatf("src_index %h, expected %h for out_index %h",
                                   got.src, want.src, want.dest));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
            stall_left = idle_len();
            rsp_tready <= (stall_left == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int n;
      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      pushed_count   = 0;
      error_count    = 0;
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      csr_model[CSR_RANK] = 1;
      for (int i = 1; i < 8; i++) csr_model[i] = '0;
      count_set = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values: element count zero drops everything
      queue_index(0);
      queue_index(1);
      queue_index('1);
      finish_phase();

      // 4-d tile of input 2x3x1x2 repeated 2x1x3x2
      rank_set  = 3'd4;
      count_set = 144;
      ostr_set  = '{36, 12, 4, 1};
      istr_set  = '{6, 2, 2, 1};
      ilen_set  = '{2, 3, 1, 2};
      load_shape();
      queue_index(0);
      queue_index(143);
      queue_index(144);
      queue_index('1);
      queue_index(77);
      queue_index(35);
      finish_phase();

      // rank zero walks no dimension
      random_raw_shape();
      rank_set  = 3'd0;
      count_set = '1;
      load_shape();
      queue_index(32'hFFFF_FFFE);
      queue_index(0);
      queue_index('1);
      queue_index(32'h8000_0000);
      finish_phase();

      // rank above four, zero stride, zero length, all-ones registers
      rank_set  = 3'd7;
      count_set = '1;
      ostr_set  = '{'1, 0, 3, 7};
      istr_set  = '{'1, '1, 5, '1};
      ilen_set  = '{3, 4, 0, '1};
      load_shape();
      queue_index(32'hFFFF_FFFE);
      queue_index(32'h1234_5678);
      queue_index(32'h7FFF_FFFF);
      queue_index(5);
      finish_phase();

      while (pushed_count < TARGET_ITEMS) begin
         if ($urandom_range(0, 9) < 7) random_tile_shape();
         else random_raw_shape();
         load_shape();
         n = $urandom_range(60, 140);
         repeat (n) queue_index(next_index());
         finish_phase();
      end

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- tensor_tile_source_index.f -----
rtl/tts_pkg.sv
rtl/tts_div_cell.sv
rtl/tts_mac_cell.sv
rtl/tts_dim.sv
rtl/tensor_tile_source_index.sv
test/tb_tensor_tile_source_index.sv
